FILE: src/shfp_pkg.sv
// shared types and constants for the sync header frame parser
package shfp_pkg;

  // hard ceiling on payload length, independent of the max_length register
  localparam int MAX_PAYLOAD = 8;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_SYNC_THIRD  = 2'd2,
    CFG_MAX_LENGTH  = 2'd3
  } cfg_idx_t;

  // header hunt stages
  typedef enum logic [2:0] {
    ST_FIRST   = 3'd0,
    ST_SECOND  = 3'd1,
    ST_THIRD   = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_PAYLOAD = 3'd4
  } stage_t;

  // reset values of the configuration registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;
  localparam logic [7:0] SYNC_THIRD_RST  = 8'hA5;
  localparam logic [3:0] MAX_LENGTH_RST  = 4'd8;

endpackage

FILE: src/sync_header_frame_parser.sv
// sync header frame parser: header hunt, length check and payload streaming
//
// Takes one received serial byte per request and hunts for a three-byte sync
// header (sync_first, sync_second, sync_third), then a length byte, then that
// many payload bytes. A header byte that does not match is dropped and the
// hunt restarts at the first header byte; the dropped byte is not re-checked
// as a new header start. A length of zero, or one above the smaller of
// max_length and the fixed ceiling of 8, is rejected the same way. Header and
// length bytes give no result; every payload byte gives one result with its
// index, the announced frame length and a last flag on the final byte.
// Timing: a request enters an input register, is parsed from there and its
// result lands in the output register, which drives out_valid. One request
// is accepted every cycle as long as the output side keeps up; a stalled
// output register holds back the parse stage, which in turn raises in_stall
// once it is occupied.
// Configuration is a plain write port and is expected only while idle.
module sync_header_frame_parser (
  input  logic       clk,
  input  logic       rst_n,
  // input requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result requests
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_byte_index,
  output logic [3:0] out_frame_length,
  output logic       out_last_byte,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  // configuration registers
  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [7:0] sync_third_r;
  logic [3:0] max_length_r;

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // parser state
  shfp_pkg::stage_t stage_r, stage_nxt;
  logic [3:0]       frame_len_r, frame_len_nxt;
  logic [2:0]       count_r, count_nxt;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [2:0] out_index_r;
  logic [3:0] out_len_r;
  logic       out_last_r;

  logic       s1_hold;
  logic       s1_fire;
  logic       in_accept;
  logic       emit;
  logic       last;
  logic [3:0] len_limit;
  logic       len_bad;

  // handshake: parse stage waits while the output register is stalled
  assign s1_hold   = out_valid_r && out_stall;
  assign s1_fire   = s1_valid_r && !s1_hold;
  assign in_stall  = s1_valid_r && s1_hold;
  assign in_accept = in_valid && !in_stall;

  // length limit is the smaller of max_length and the fixed ceiling
  assign len_limit = (max_length_r > 4'(shfp_pkg::MAX_PAYLOAD)) ?
                     4'(shfp_pkg::MAX_PAYLOAD) : max_length_r;
  assign len_bad   = (s1_byte_r == 8'd0) || (s1_byte_r > {4'd0, len_limit});

  // next state of the hunt
  always_comb begin
    stage_nxt     = stage_r;
    frame_len_nxt = frame_len_r;
    count_nxt     = count_r;
    unique case (stage_r)
      shfp_pkg::ST_SECOND: begin
        stage_nxt = (s1_byte_r == sync_second_r) ? shfp_pkg::ST_THIRD :
                                                   shfp_pkg::ST_FIRST;
      end
      shfp_pkg::ST_THIRD: begin
        stage_nxt = (s1_byte_r == sync_third_r) ? shfp_pkg::ST_LENGTH :
                                                  shfp_pkg::ST_FIRST;
      end
      shfp_pkg::ST_LENGTH: begin
        if (len_bad) begin
          stage_nxt = shfp_pkg::ST_FIRST;
        end else begin
          stage_nxt     = shfp_pkg::ST_PAYLOAD;
          frame_len_nxt = s1_byte_r[3:0];
        end
      end
      shfp_pkg::ST_PAYLOAD: begin
        if (last) begin
          stage_nxt = shfp_pkg::ST_FIRST;
        end else begin
          count_nxt = count_r + 3'd1;
        end
      end
      default: begin
        // unreachable codes behave like the first header stage
        stage_nxt = (s1_byte_r == sync_first_r) ? shfp_pkg::ST_SECOND :
                                                  shfp_pkg::ST_FIRST;
      end
    endcase
    // a restarted hunt clears the frame bookkeeping
    if (stage_nxt == shfp_pkg::ST_FIRST) begin
      frame_len_nxt = 4'd0;
      count_nxt     = 3'd0;
    end
  end

  // outputs of the hunt: only payload bytes give a result
  always_comb begin
    emit = 1'b0;
    last = 1'b0;
    unique case (stage_r)
      shfp_pkg::ST_PAYLOAD: begin
        emit = 1'b1;
        last = ({1'b0, count_r} + 4'd1) >= frame_len_r;
      end
      default: begin
        emit = 1'b0;
        last = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= shfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= shfp_pkg::SYNC_SECOND_RST;
      sync_third_r  <= shfp_pkg::SYNC_THIRD_RST;
      max_length_r  <= shfp_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (shfp_pkg::cfg_idx_t'(cfg_index))
        shfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        shfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        shfp_pkg::CFG_SYNC_THIRD:  sync_third_r  <= cfg_wdata;
        shfp_pkg::CFG_MAX_LENGTH:  max_length_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // parser state advances once per parsed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= shfp_pkg::ST_FIRST;
      frame_len_r <= 4'd0;
      count_r     <= 3'd0;
    end else if (s1_fire) begin
      stage_r     <= stage_nxt;
      frame_len_r <= frame_len_nxt;
      count_r     <= count_nxt;
    end
  end

  // output register; free whenever the parse stage fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_byte_r  <= s1_byte_r;
      out_index_r <= count_r;
      out_len_r   <= frame_len_r;
      out_last_r  <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_index_r;
  assign out_frame_length = out_len_r;
  assign out_last_byte    = out_last_r;

`ifndef NO_ASSERTIONS
  // a parsed payload byte always shows up as a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && stage_r == shfp_pkg::ST_PAYLOAD |=> out_valid)
    else $error("payload byte did not reach the output register");

  // index stays inside the announced frame
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_byte_index} < out_frame_length))
    else $error("byte index beyond frame length");

  // last flag exactly on the final byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (({1'b0, out_byte_index} + 4'd1) == out_frame_length)))
    else $error("last flag does not match final byte");

  // payload stage always holds a legal frame length
  assert property (@(posedge clk) disable iff (!rst_n)
    stage_r == shfp_pkg::ST_PAYLOAD |->
      (frame_len_r != 4'd0) && (frame_len_r <= 4'(shfp_pkg::MAX_PAYLOAD)) &&
      ({1'b0, count_r} < frame_len_r))
    else $error("payload stage with illegal length or count");
`endif

endmodule

FILE: verif/sync_header_frame_parser_test.sv
// self-checking testbench for the sync header frame parser
module sync_header_frame_parser_test;

  localparam int HOLD_CYCLES    = 40;    // long receiver hold-off that fills the pipe
  localparam int QUIET_CYCLES   = 6;     // lets the input register drain before a cfg write
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request moving on either side
  localparam int MAX_REPORTS    = 10;

  // one result request as the block presents it
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] idx;
    logic [3:0] len;
    logic       last;
  } payload_rec_t;

  // one row of the directed stimulus; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    logic         gives;
    payload_rec_t want;
  } vec_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_payload_byte;
  logic [2:0] out_byte_index;
  logic [3:0] out_frame_length;
  logic       out_last_byte;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  sync_header_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last_byte    (out_last_byte),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // parser mirror: configuration copy and hunt state
  logic [7:0]       sync_a, sync_b, sync_c;
  logic [3:0]       max_len;
  shfp_pkg::stage_t hunt;
  logic [3:0]       flen;
  logic [3:0]       pcount;

  payload_rec_t pending_payload [$];   // payload results still owed by the block
  int           mismatch_cnt = 0;
  int           rx_sent      = 0;
  int           idle_run     = 0;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic         long_hold    = 1'b0;
  vec_row_t     directed_rows [23];

  // clock: period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void restart_hunt();
    hunt   = shfp_pkg::ST_FIRST;
    flen   = '0;
    pcount = '0;
  endfunction

  // advance the mirror by one received byte; returns 1 when a payload result is due
  function automatic logic parse_rx(input logic [7:0] b, output payload_rec_t rec);
    logic [3:0] lim;
    logic [4:0] nxt;
    rec = '0;
    parse_rx = 1'b0;
    // effective ceiling is the smaller of the register and the fixed maximum
    lim = (max_len > 4'(shfp_pkg::MAX_PAYLOAD)) ? 4'(shfp_pkg::MAX_PAYLOAD) : max_len;
    case (hunt)
      shfp_pkg::ST_SECOND: begin
        if (b == sync_b) hunt = shfp_pkg::ST_THIRD;
        else restart_hunt();
      end
      shfp_pkg::ST_THIRD: begin
        if (b == sync_c) hunt = shfp_pkg::ST_LENGTH;
        else restart_hunt();
      end
      shfp_pkg::ST_LENGTH: begin
        // zero length and anything above the ceiling restart the hunt
        if (b == 8'd0 || b > {4'd0, lim}) begin
          restart_hunt();
        end else begin
          flen   = b[3:0];
          pcount = '0;
          hunt   = shfp_pkg::ST_PAYLOAD;
        end
      end
      shfp_pkg::ST_PAYLOAD: begin
        nxt = {1'b0, pcount} + 5'd1;
        rec.data = b;
        rec.idx  = pcount[2:0];
        rec.len  = flen;
        rec.last = (nxt >= {1'b0, flen});
        parse_rx = 1'b1;
        if (rec.last) restart_hunt();
        else pcount = nxt[3:0];
      end
      default: begin
        // first header byte; unused stage codes behave the same way
        if (b == sync_a) hunt = shfp_pkg::ST_SECOND;
        else restart_hunt();
      end
    endcase
  endfunction

  function automatic vec_row_t vec(input logic [7:0] rx, input logic typed, input logic gives,
                                   input logic [7:0] data, input logic [2:0] idx,
                                   input logic [3:0] len, input logic last);
    vec = '{rx, typed, gives, '{data, idx, len, last}};
  endfunction

  // offer one request on the input side, with random gaps before it
  task automatic feed_rx(input logic [7:0] b, input logic typed, input logic gives,
                         input payload_rec_t want);
    payload_rec_t rec;
    logic         made;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: step the mirror in request order
    made = parse_rx(b, rec);
    if (typed) begin
      made = gives;
      rec  = want;
    end
    if (made) pending_payload.push_back(rec);
    rx_sent++;
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [7:0] b);
    feed_rx(b, 1'b0, 1'b0, '0);
  endtask

  // register write, only issued while the block is idle
  task automatic cfg_write(input shfp_pkg::cfg_idx_t idx, input logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      shfp_pkg::CFG_SYNC_FIRST:  sync_a  = val;
      shfp_pkg::CFG_SYNC_SECOND: sync_b  = val;
      shfp_pkg::CFG_SYNC_THIRD:  sync_c  = val;
      shfp_pkg::CFG_MAX_LENGTH:  max_len = val[3:0];
      default: ;
    endcase
  endtask

  // sender pause until every owed result has come out, then let the pipe empty
  task automatic settle();
    in_valid = 1'b0;
    while (pending_payload.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // random traffic: mostly well-formed frames, some broken ones, some line noise
  task automatic run_frames(input int n);
    int         target;
    int         kind;
    int         bad_pos;
    int         len;
    logic [3:0] lim;
    logic [7:0] hdr [3];
    logic [7:0] b;
    target = rx_sent + n;
    while (rx_sent < target) begin
      lim    = (max_len > 4'(shfp_pkg::MAX_PAYLOAD)) ? 4'(shfp_pkg::MAX_PAYLOAD) : max_len;
      hdr[0] = sync_a;
      hdr[1] = sync_b;
      hdr[2] = sync_c;
      kind   = $urandom_range(99);
      if (kind < 15) begin
        // line noise burst
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
      end else begin
        // well-formed or broken frames; a broken one spoils one header byte or the length byte
        bad_pos = (kind < 32) ? $urandom_range(0, 3) : 4;
        for (int i = 0; i < 3; i++) begin
          b = hdr[i];
          if (i == bad_pos) b = hdr[i] ^ 8'($urandom_range(1, 255));
          send_rx(b);
        end
        if (bad_pos == 3 || lim == 0) begin
          case ($urandom_range(3))
            0: b = 8'd0;
            1: b = {4'd0, lim} + 8'd1;
            2: b = 8'($urandom_range(int'(lim) + 1, 255));
            // low nibble looks legal, high nibble makes it too long
            default: b = {4'($urandom_range(1, 15)),
                          (lim == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, lim))};
          endcase
          len = $urandom_range(0, 3);
        end else begin
          len = $urandom_range(1, lim);
          b   = 8'(len);
        end
        send_rx(b);
        repeat (len) send_rx(8'($urandom));
      end
    end
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input payload_rec_t want,
                                 input payload_rec_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch: %s exp %02h/%0d/%0d/%0b got %02h/%0d/%0d/%0b",
               what, want.data, want.idx, want.len, want.last,
               got.data, got.idx, got.len, got.last);
  endtask

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    payload_rec_t got;
    payload_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_payload_byte, out_byte_index, out_frame_length, out_last_byte};
      if (pending_payload.size() == 0) begin
        report_mismatch("result with nothing owed", '0, got);
      end else begin
        want = pending_payload.pop_front();
        if (got.data !== want.data || got.idx !== want.idx ||
            got.len !== want.len || got.last !== want.last)
          report_mismatch("payload fields", want, got);
      end
    end
  end

  // watchdog: ends a run in which no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    in_valid      = 1'b0;
    in_rx_byte    = 8'd0;
    cfg_we        = 1'b0;
    cfg_index     = shfp_pkg::CFG_SYNC_FIRST;
    cfg_wdata     = 8'd0;
    rst_n         = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 56;
    sync_a        = shfp_pkg::SYNC_FIRST_RST;
    sync_b        = shfp_pkg::SYNC_SECOND_RST;
    sync_c        = shfp_pkg::SYNC_THIRD_RST;
    max_len       = shfp_pkg::MAX_LENGTH_RST;
    restart_hunt();

    // directed requests against the reset configuration
    directed_rows = '{
      // mismatch on the first header byte
      vec(8'h00, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // mismatch on the second header byte
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h00, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // mismatch on the third header byte
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h5A, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h00, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // zero length is rejected
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h5A, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'hA5, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h00, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // length one above the ceiling is rejected
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h5A, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'hA5, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h09, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // a dropped header byte is not taken as a new header start
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'hFF, 1'b0, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h5A, 1'b0, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      // clean two-byte frame with extreme payload values
      vec(8'hFF, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h5A, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'hA5, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'h02, 1'b1, 1'b0, 8'h00, 3'd0, 4'd0, 1'b0),
      vec(8'hFF, 1'b1, 1'b1, 8'hFF, 3'd0, 4'd2, 1'b0),
      vec(8'h00, 1'b1, 1'b1, 8'h00, 3'd1, 4'd2, 1'b1)
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      feed_rx(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].gives,
              directed_rows[i].want);

    // random phases: each one on an idle block with a fresh configuration
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 56;
      end else if (ph < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'h00);
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'hFF);
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'h00);
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, 8'h08);
        end
        1: begin
          // register above the fixed maximum: ceiling stays at 8
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'($urandom));
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, 8'h0F);
        end
        2: begin
          // zero ceiling: every length byte is rejected, no results at all
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'h5A);
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'h5A);
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'h5A);
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, 8'h00);
        end
        3: begin
          // high bits of the write data are dropped, ceiling becomes 3
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'($urandom));
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, 8'hF3);
        end
        4: begin
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'hFF);
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'hFF);
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'hFF);
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, 8'h01);
        end
        default: begin
          cfg_write(shfp_pkg::CFG_SYNC_FIRST, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_SECOND, 8'($urandom));
          cfg_write(shfp_pkg::CFG_SYNC_THIRD, 8'($urandom));
          cfg_write(shfp_pkg::CFG_MAX_LENGTH, {4'($urandom), 4'($urandom_range(1, 15))});
        end
      endcase
      // long receiver hold-off while the sender keeps offering requests
      if (ph == 1 || ph == 4) long_hold = 1'b1;
      run_frames((ph == 2) ? 40 : 85);
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
